/* design/bpa_pkg.sv */
// Shared types, codes and helpers for the bitmap page allocator.
// No dependencies; bpa_scan_unit, the top level and the checker import it.
package bpa_pkg;

   localparam int unsigned WORD_BITS = 32;
   localparam int unsigned FRAME_W   = 10;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned RESV_W    = 11;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FREED     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 2'd3;

   typedef struct packed {
      logic       found;
      logic [4:0] bit_idx;
   } scan_result_type;

   // lowest set bit of a bitmap word
   function automatic scan_result_type lowest_set(input logic [WORD_BITS-1:0] vec);
      scan_result_type res;
      res.found   = 1'b0;
      res.bit_idx = 5'd0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            res.found   = 1'b1;
            res.bit_idx = 5'(i);
         end
      end
      return res;
   endfunction

endpackage

/* design/bpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/bpa_scan_unit.sv */
// Word evaluator: folds reserved frames and frames past the end into one
// bitmap word and finds its lowest free bit. Depends on bpa_pkg.
module bpa_scan_unit
   import bpa_pkg::*;
#(
   parameter int unsigned FRAMES = 1024
) (
   input  logic [WORD_BITS-1:0]                                  word_data,
   input  logic [(((FRAMES + 31) / 32) > 1 ?
                  $clog2((FRAMES + 31) / 32) : 1)-1:0]            word_index,
   input  logic [RESV_W-1:0]                                     reserved,
   output scan_result_type                                       result
);

   localparam int unsigned WORDS = (FRAMES + 31) / 32;
   localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned CW    = WAW + 5;
   localparam int unsigned RW    = ((CW > RESV_W) ? CW : RESV_W) + 1;
   localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
   localparam logic [WORD_BITS-1:0] TAIL_USED = (FRAMES % 32 == 0) ? 32'h0 :
      ~((32'h1 << (FRAMES % 32)) - 32'h1);

   logic [RW-1:0]        res_x;
   logic [RW-1:0]        base_x;
   logic [RW-1:0]        diff;
   logic [WORD_BITS-1:0] resv_mask;
   logic [WORD_BITS-1:0] tail_mask;

   always_comb begin
      res_x  = RW'(reserved);
      base_x = RW'({word_index, 5'd0});
      diff   = res_x - base_x;
      if (res_x <= base_x) begin
         resv_mask = '0;
      end else if (diff >= RW'(WORD_BITS)) begin
         resv_mask = '1;
      end else begin
         resv_mask = (32'h1 << diff[4:0]) - 32'h1;
      end
      tail_mask = (word_index == LAST_WORD) ? TAIL_USED : '0;
      result    = lowest_set(~(word_data | resv_mask | tail_mask));
   end

endmodule

/* design/bitmap_page_allocator_top.sv */
// First-fit page frame allocator over a used/free bitmap kept in one RAM of
// 32-bit words. After reset a clearing pass writes one word a cycle, and the
// block stalls requests until it has written the last word; configuration
// writes are taken at any time. An allocate walks the bitmap one word a cycle
// through a single word evaluator, ending early at the first free frame. A
// free is a read-modify-write of one word; a free aimed at a reserved or
// absent frame is answered as ignored without touching the bitmap. One
// request is in flight at a time; the result word sits in an output register
// so the next request is taken while it waits. Depends on bpa_pkg, bpa_ram
// and bpa_scan_unit.
module bitmap_page_allocator_top
   import bpa_pkg::*;
#(
   parameter int unsigned FRAMES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_func,
   input  logic [FRAME_W-1:0]  req_page_number,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [FRAME_W-1:0]  rsp_frame,
   output logic [STATUS_W-1:0] rsp_status,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [RESV_W-1:0]   csr_reserved_pages
);

   localparam int unsigned WORDS = (FRAMES + 31) / 32;
   localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned CW    = WAW + 5;
   localparam int unsigned XW    = (CW > FRAME_W) ? CW : FRAME_W;
   localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_DELIVER
   } state_type;

   state_type             state_ff, state_in;
   logic [WAW-1:0]        clr_ff, clr_in;
   logic [WAW-1:0]        scan_ff, scan_in;
   logic [WAW-1:0]        eval_ff, eval_in;
   logic                  issuing_ff, issuing_in;
   logic                  pend_ff, pend_in;
   logic [FRAME_W-1:0]    page_ff, page_in;
   logic [FRAME_W-1:0]    res_frame_ff, res_frame_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]    rsp_frame_ff, rsp_frame_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [RESV_W-1:0]     reserved_ff, reserved_in;

   logic                  ram_wr_en;
   logic [WAW-1:0]        ram_wr_addr;
   logic [WORD_BITS-1:0]  ram_wr_data;
   logic [WAW-1:0]        ram_rd_addr;
   logic [WORD_BITS-1:0]  ram_rd_data;
   scan_result_type       scan_res;

   logic                  req_take;
   logic                  free_ok;
   logic [XW-1:0]         page_x;
   logic [WAW-1:0]        page_word;
   logic [XW-1:0]         found_x;

   bpa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bpa_scan_unit #(
      .FRAMES (FRAMES)
   ) u_scan (
      .word_data  (ram_rd_data),
      .word_index (eval_ff),
      .reserved   (reserved_ff),
      .result     (scan_res)
   );

   assign req_take  = req_valid && !req_stall;
   assign free_ok   = (17'(req_page_number) < 17'(FRAMES)) &&
                      (RESV_W'(req_page_number) >= reserved_ff);
   assign page_x    = XW'(page_ff);
   assign page_word = page_x[WAW+4:5];
   assign found_x   = XW'({eval_ff, scan_res.bit_idx});

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      scan_in       = scan_ff;
      eval_in       = eval_ff;
      issuing_in    = issuing_ff;
      pend_in       = pend_ff;
      page_in       = page_ff;
      res_frame_in  = res_frame_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_status_in = rsp_status_ff;
      reserved_in   = reserved_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_ff;
      ram_wr_data = '0;
      ram_rd_addr = scan_ff;

      if (csr_valid) begin
         reserved_in = csr_reserved_pages;
      end

      // drop the result word once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            if (clr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               page_in = req_page_number;
               if (req_func == FUNC_ALLOC) begin
                  scan_in    = '0;
                  issuing_in = 1'b1;
                  pend_in    = 1'b0;
                  state_in   = ST_SCAN;
               end else if (free_ok) begin
                  state_in = ST_FREE_RD;
               end else begin
                  res_frame_in  = '0;
                  res_status_in = STATUS_IGNORED;
                  state_in      = ST_DELIVER;
               end
            end
         end
         ST_SCAN: begin
            // issue the next word while the previous one is evaluated
            pend_in = issuing_ff;
            if (issuing_ff) begin
               eval_in = scan_ff;
               if (scan_ff == LAST_WORD) begin
                  issuing_in = 1'b0;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
            if (pend_ff) begin
               if (scan_res.found) begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = eval_ff;
                  ram_wr_data   = ram_rd_data | (32'h1 << scan_res.bit_idx);
                  res_frame_in  = found_x[FRAME_W-1:0];
                  res_status_in = STATUS_ALLOCATED;
                  issuing_in    = 1'b0;
                  state_in      = ST_DELIVER;
               end else if (eval_ff == LAST_WORD) begin
                  res_frame_in  = '0;
                  res_status_in = STATUS_FULL;
                  state_in      = ST_DELIVER;
               end
            end
         end
         ST_FREE_RD: begin
            ram_rd_addr = page_word;
            state_in    = ST_FREE_WR;
         end
         ST_FREE_WR: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = page_word;
            ram_wr_data   = ram_rd_data & ~(32'h1 << page_ff[4:0]);
            res_frame_in  = '0;
            res_status_in = STATUS_FREED;
            state_in      = ST_DELIVER;
         end
         ST_DELIVER: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_frame_in  = res_frame_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         issuing_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         reserved_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         issuing_ff   <= issuing_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         reserved_ff  <= reserved_in;
      end
      scan_ff       <= scan_in;
      eval_ff       <= eval_in;
      page_ff       <= page_in;
      res_frame_ff  <= res_frame_in;
      res_status_ff <= res_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_frame  = rsp_frame_ff;
   assign rsp_status = rsp_status_ff;
   assign csr_ready  = 1'b1;

endmodule

/* design/bpa_checker.sv */
// Port-level checks for the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg and bitmap_page_allocator_top.
module bpa_checker
   import bpa_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [FRAME_W-1:0]  rsp_frame,
   input logic [STATUS_W-1:0] rsp_status
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame) && $stable(rsp_status))
      else $error("result word changed while stalled");

   // clearing pass follows reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_stall)
      else $error("request taken during clearing pass");

   // one request in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in flight");

   a_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_ALLOCATED) |-> rsp_frame == '0)
      else $error("frame not zero on a non-allocation result");

endmodule

bind bitmap_page_allocator_top bpa_checker u_bpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_frame  (rsp_frame),
   .rsp_status (rsp_status)
);
